FILE: design/pidoo_pkg.sv
// ----------------------------------------------------------------------------
// pidoo_pkg: shared types, codes and microcode for the PID on/off controller
// Holds the register indexes, the datapath operation and jump-condition codes,
// the control word layout and the read-only microprogram.
// ----------------------------------------------------------------------------
package pidoo_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RUN_ENABLE = 3'd0;
  localparam logic [2:0] REG_SETPOINT   = 3'd1;
  localparam logic [2:0] REG_KP         = 3'd2;
  localparam logic [2:0] REG_KI         = 3'd3;
  localparam logic [2:0] REG_KD         = 3'd4;

  // Datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_ERR  = 3'd1;
  localparam logic [2:0] OP_SUM  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_OUT  = 3'd5;
  localparam logic [2:0] OP_ZERO = 3'd6;

  // Jump conditions
  localparam logic [2:0] CND_NEXT     = 3'd0;
  localparam logic [2:0] CND_NO_BEAT  = 3'd1;
  localparam logic [2:0] CND_NO_RUN   = 3'd2;
  localparam logic [2:0] CND_DIV_MORE = 3'd3;
  localparam logic [2:0] CND_OUT_BUSY = 3'd4;

  // Program steps
  localparam logic [2:0] STEP_WAIT = 3'd0;
  localparam logic [2:0] STEP_ERR  = 3'd1;
  localparam logic [2:0] STEP_SUM  = 3'd2;
  localparam logic [2:0] STEP_MUL  = 3'd3;
  localparam logic [2:0] STEP_DIV  = 3'd4;
  localparam logic [2:0] STEP_OUT  = 3'd5;
  localparam logic [2:0] STEP_ZERO = 3'd6;
  localparam logic [2:0] STEP_LAST = 3'd6;

  // Divider: one quotient bit per cycle over the 32-bit magnitude
  localparam int DIV_BITS = 32;
  localparam logic [4:0] DIV_LAST_CNT = 5'(DIV_BITS - 1);

  // One control word of the microprogram
  typedef struct packed {
    logic       in_ready;
    logic [2:0] op;
    logic [2:0] cond;
    logic [2:0] target;
    logic       done;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic [2:0] op;
    logic       in_beat;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic out_busy;
    logic div_more;
  } stat_t;

  // Microprogram ROM
  function automatic ucode_t ucode_rom(input logic [2:0] pc);
    ucode_t w;
    w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_NEXT, target: STEP_WAIT, done: 1'b1};
    case (pc)
      STEP_WAIT: w = '{in_ready: 1'b1, op: OP_NOP, cond: CND_NO_BEAT,
                       target: STEP_WAIT, done: 1'b0};
      STEP_ERR:  w = '{in_ready: 1'b0, op: OP_ERR, cond: CND_NO_RUN,
                       target: STEP_ZERO, done: 1'b0};
      STEP_SUM:  w = '{in_ready: 1'b0, op: OP_SUM, cond: CND_NEXT,
                       target: STEP_WAIT, done: 1'b0};
      STEP_MUL:  w = '{in_ready: 1'b0, op: OP_MUL, cond: CND_NEXT,
                       target: STEP_WAIT, done: 1'b0};
      STEP_DIV:  w = '{in_ready: 1'b0, op: OP_DIV, cond: CND_DIV_MORE,
                       target: STEP_DIV, done: 1'b0};
      STEP_OUT:  w = '{in_ready: 1'b0, op: OP_OUT, cond: CND_OUT_BUSY,
                       target: STEP_OUT, done: 1'b1};
      STEP_ZERO: w = '{in_ready: 1'b0, op: OP_ZERO, cond: CND_OUT_BUSY,
                       target: STEP_ZERO, done: 1'b1};
      default:   w = '{in_ready: 1'b0, op: OP_NOP, cond: CND_NEXT,
                       target: STEP_WAIT, done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

FILE: design/pidoo_seq.sv
// ----------------------------------------------------------------------------
// pidoo_seq: microprogram sequencer
// Steps through the control ROM; each word drives the datapath and selects a
// conditional jump, a fall-through or a return to the wait step.
// ----------------------------------------------------------------------------
module pidoo_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  run_enable,
  input  pidoo_pkg::stat_t      stat,
  output logic                  in_ready,
  output pidoo_pkg::ctrl_t      ctrl
);

  logic [2:0]        pc;
  logic [2:0]        pc_next;
  pidoo_pkg::ucode_t word;
  logic              take;

  // Fetch the current control word
  assign word = pidoo_pkg::ucode_rom(pc);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      pidoo_pkg::CND_NEXT:     take = 1'b0;
      pidoo_pkg::CND_NO_BEAT:  take = !in_valid;
      pidoo_pkg::CND_NO_RUN:   take = !run_enable;
      pidoo_pkg::CND_DIV_MORE: take = stat.div_more;
      pidoo_pkg::CND_OUT_BUSY: take = stat.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  // Select the next step
  always_comb begin
    if (take) begin
      pc_next = word.target;
    end else if (word.done) begin
      pc_next = pidoo_pkg::STEP_WAIT;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pidoo_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready     = word.in_ready;
  assign ctrl.op      = word.op;
  assign ctrl.in_beat = word.in_ready && in_valid;

  // The step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= pidoo_pkg::STEP_LAST)
    else $error("step counter left the program");

  // An accepted beat always moves on to the error step
  a_beat_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (pc == pidoo_pkg::STEP_ERR))
    else $error("accepted beat did not advance the program");

  // The divide loop exits only into the output step
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (pc == pidoo_pkg::STEP_DIV && !stat.div_more) |=> (pc == pidoo_pkg::STEP_OUT))
    else $error("divide loop exited to the wrong step");

endmodule

FILE: design/pidoo_dp.sv
// ----------------------------------------------------------------------------
// pidoo_dp: PID datapath
// Error and derivative, saturating integral, two gain multipliers, a
// bit-serial restoring divider for the integral term and the result register.
// ----------------------------------------------------------------------------
module pidoo_dp (
  input  logic                clk,
  input  logic                rst,
  input  pidoo_pkg::ctrl_t    ctrl,
  input  logic [11:0]         measured_temp,
  input  logic [7:0]          setpoint,
  input  logic [7:0]          kp,
  input  logic [7:0]          ki,
  input  logic [7:0]          kd,
  input  logic                out_ready,
  output pidoo_pkg::stat_t    stat,
  output logic                out_valid,
  output logic                drive_on,
  output logic [12:0]         error_value,
  output logic [31:0]         integral_value,
  output logic [13:0]         derivative_value,
  output logic [31:0]         control_value
);

  logic signed [11:0] meas;
  logic signed [12:0] err_q;
  logic signed [12:0] prev_err;
  logic signed [13:0] deriv_q;
  logic signed [31:0] error_sum;
  logic signed [31:0] sum_q;
  logic signed [21:0] prod_p;
  logic signed [22:0] prod_d;
  logic [31:0]        dq;
  logic [7:0]         rem;
  logic [4:0]         cnt;

  logic signed [12:0] err_next;
  logic signed [13:0] deriv_next;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [21:0] prod_p_next;
  logic signed [22:0] prod_d_next;
  logic [8:0]         shifted;
  logic [8:0]         diff;
  logic               fits;
  logic signed [33:0] q_ext;
  logic signed [33:0] q_signed;
  logic signed [33:0] iterm;
  logic signed [33:0] total;
  logic signed [31:0] ctrl_sat;
  logic               out_load;

  // Error and derivative
  assign err_next   = $signed({5'b0, setpoint}) - $signed({meas[11], meas});
  assign deriv_next = $signed({err_next[12], err_next}) - $signed({prev_err[12], prev_err});

  // Saturating integral
  assign sum_wide = $signed({error_sum[31], error_sum}) + $signed({{20{err_q[12]}}, err_q});
  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // Gain products
  assign prod_p_next = $signed({1'b0, kp}) * err_q;
  assign prod_d_next = $signed({1'b0, kd}) * deriv_q;

  // One restoring divide step on the magnitude
  assign shifted = {rem, dq[31]};
  assign diff    = shifted - {1'b0, ki};
  assign fits    = shifted >= {1'b0, ki};

  // Control sum with the signed, truncated quotient
  assign q_ext    = $signed({2'b00, dq});
  assign q_signed = sum_q[31] ? -q_ext : q_ext;
  assign iterm    = (ki != 8'd0) ? q_signed : 34'sd0;
  assign total    = $signed({{12{prod_p[21]}}, prod_p})
                  + $signed({{11{prod_d[22]}}, prod_d}) + iterm;
  always_comb begin
    if (total[33:31] != {3{total[33]}}) begin
      ctrl_sat = total[33] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    end else begin
      ctrl_sat = total[31:0];
    end
  end

  assign stat.out_busy = out_valid && !out_ready;
  assign stat.div_more = cnt != 5'd0;
  assign out_load = ((ctrl.op == pidoo_pkg::OP_OUT) || (ctrl.op == pidoo_pkg::OP_ZERO))
                    && !stat.out_busy;

  // Working registers, driven by the current operation
  always_ff @(posedge clk) begin
    if (ctrl.in_beat) begin
      meas <= $signed(measured_temp);
    end
    case (ctrl.op)
      pidoo_pkg::OP_ERR: begin
        err_q   <= err_next;
        deriv_q <= deriv_next;
      end
      pidoo_pkg::OP_SUM: begin
        sum_q  <= sum_sat;
        prod_p <= prod_p_next;
      end
      pidoo_pkg::OP_MUL: begin
        prod_d <= prod_d_next;
        dq     <= sum_q[31] ? 32'(-sum_q) : 32'(sum_q);
        rem    <= 8'd0;
      end
      pidoo_pkg::OP_DIV: begin
        rem <= fits ? diff[7:0] : shifted[7:0];
        dq  <= {dq[30:0], fits};
      end
      default: begin
      end
    endcase
  end

  // Loop state and divide counter
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
      prev_err  <= '0;
      cnt       <= '0;
    end else begin
      case (ctrl.op)
        pidoo_pkg::OP_SUM: begin
          error_sum <= sum_sat;
          prev_err  <= err_q;
        end
        pidoo_pkg::OP_MUL: begin
          cnt <= pidoo_pkg::DIV_LAST_CNT;
        end
        pidoo_pkg::OP_DIV: begin
          if (cnt != 5'd0) begin
            cnt <= cnt - 5'd1;
          end
        end
        pidoo_pkg::OP_ZERO: begin
          error_sum <= '0;
          prev_err  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ctrl.op == pidoo_pkg::OP_OUT) begin
        drive_on         <= !ctrl_sat[31] && (ctrl_sat != 32'sd0);
        error_value      <= err_q;
        integral_value   <= sum_q;
        derivative_value <= deriv_q;
        control_value    <= ctrl_sat;
      end else begin
        drive_on         <= 1'b0;
        error_value      <= '0;
        integral_value   <= '0;
        derivative_value <= '0;
        control_value    <= '0;
      end
    end
  end

  // Drive is on only for a positive control value
  a_drive_sign: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_on) |-> (!control_value[31] && control_value != 32'd0))
    else $error("drive on without a positive control value");

  // A stopped tick clears the loop state and presents a zero result
  a_zero_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && ctrl.op == pidoo_pkg::OP_ZERO)
      |=> (error_sum == 32'sd0 && prev_err == 13'sd0 && out_valid && !drive_on))
    else $error("stopped tick left loop state or drive set");

  // A running result reports the integral that was just stored
  a_sum_match: assert property (@(posedge clk) disable iff (rst)
    (out_load && ctrl.op == pidoo_pkg::OP_OUT) |=> (integral_value == error_sum))
    else $error("reported integral differs from stored integral");

endmodule

FILE: design/pid_on_off_controller.sv
// ----------------------------------------------------------------------------
// pid_on_off_controller: PID loop with a relay (on/off) heater output
// Top level: configuration registers, microprogram sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input beat is one control tick carrying a measured temperature; each
// tick yields exactly one result beat. A running tick reaches the result
// register through the error, integral, multiply, divide and output steps,
// the one-bit-per-cycle divider working out the integral term; a new tick is
// taken only at the wait step that follows. A stopped tick (run_enable low)
// goes from the error step to the zero step instead. The next tick is accepted
// while a finished result still waits in the output register; a second
// finished result holds the program at its output step, which stalls the
// input. Configuration writes take effect at once and are meant for idle
// periods only.
module pid_on_off_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] measured_temp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        drive_on,
  output logic [12:0] error_value,
  output logic [31:0] integral_value,
  output logic [13:0] derivative_value,
  output logic [31:0] control_value
);

  logic             run_enable;
  logic [7:0]       setpoint;
  logic [7:0]       kp;
  logic [7:0]       ki;
  logic [7:0]       kd;
  pidoo_pkg::ctrl_t ctrl;
  pidoo_pkg::stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable <= 1'b0;
      setpoint   <= '0;
      kp         <= '0;
      ki         <= '0;
      kd         <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        pidoo_pkg::REG_RUN_ENABLE: run_enable <= cfg_data[0];
        pidoo_pkg::REG_SETPOINT:   setpoint   <= cfg_data;
        pidoo_pkg::REG_KP:         kp         <= cfg_data;
        pidoo_pkg::REG_KI:         ki         <= cfg_data;
        pidoo_pkg::REG_KD:         kd         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pidoo_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .run_enable (run_enable),
    .stat       (stat),
    .in_ready   (in_ready),
    .ctrl       (ctrl)
  );

  pidoo_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .measured_temp    (measured_temp),
    .setpoint         (setpoint),
    .kp               (kp),
    .ki               (ki),
    .kd               (kd),
    .out_ready        (out_ready),
    .stat             (stat),
    .out_valid        (out_valid),
    .drive_on         (drive_on),
    .error_value      (error_value),
    .integral_value   (integral_value),
    .derivative_value (derivative_value),
    .control_value    (control_value)
  );

endmodule
